/* hw/rtl/fjop_pkg.sv */
`default_nettype none
// ============================================================================
// fjop_pkg
// Shared types and constants of the flat JSON object byte parser.
// ============================================================================
package fjop_pkg;

	// Table and token sizes
	localparam int MAX_PAIRS   = 8;
	localparam int TOKEN_BYTES = 32;

	localparam int PAIR_W = $clog2(MAX_PAIRS + 1);
	localparam int TLEN_W = 5;
	localparam int IDX_W  = 3;

	localparam logic [PAIR_W-1:0] PAIR_LIMIT = PAIR_W'(MAX_PAIRS);
	localparam logic [TLEN_W-1:0] TLEN_LIMIT = TLEN_W'(TOKEN_BYTES - 1);

	// Character codes
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Byte roles
	localparam logic [1:0] ROLE_NONE = 2'd0;
	localparam logic [1:0] ROLE_KEY  = 2'd1;
	localparam logic [1:0] ROLE_STR  = 2'd2;
	localparam logic [1:0] ROLE_NUM  = 2'd3;

	// Number saturation
	localparam logic [31:0] MAG_CAP  = 32'h8000_0000;
	localparam logic [31:0] POS_SAT  = 32'h7FFF_FFFF;

	typedef enum logic [3:0] {
		BC_LBRACE,
		BC_RBRACE,
		BC_COLON,
		BC_COMMA,
		BC_QUOTE,
		BC_MINUS,
		BC_DIGIT,
		BC_SPACE,
		BC_OTHER
	} byte_class_t;

	// One classified byte as it travels through the queue
	typedef struct packed {
		byte_class_t cls;
		logic [7:0]  raw;
		logic [3:0]  digit;
	} tok_t;

	// One result item
	typedef struct packed {
		logic              accepted;
		logic [1:0]        byte_role;
		logic [7:0]        char_out;
		logic [4:0]        char_position;
		logic [IDX_W-1:0]  entry_index;
		logic              pair_done;
		logic              pair_is_number;
		logic [31:0]       number_value;
		logic              message_done;
		logic [3:0]        pair_total;
	} res_t;

endpackage
`default_nettype wire

/* hw/rtl/fjop_front.sv */
`default_nettype none
// ============================================================================
// fjop_front
// Accepts input bytes, classifies them and holds them in a two-entry queue.
// ============================================================================
module fjop_front import fjop_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [7:0] in_byte,
	output logic      q_valid,
	output tok_t      q_tok,
	input  wire logic q_pop
);

	tok_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	tok_t       tok_in;
	logic       push;

	// classifier
	always_comb begin
		tok_in.raw   = in_byte;
		tok_in.digit = 4'(in_byte - CH_ZERO);
		case (in_byte)
			CH_LBRACE: tok_in.cls = BC_LBRACE;
			CH_RBRACE: tok_in.cls = BC_RBRACE;
			CH_COLON:  tok_in.cls = BC_COLON;
			CH_COMMA:  tok_in.cls = BC_COMMA;
			CH_QUOTE:  tok_in.cls = BC_QUOTE;
			CH_MINUS:  tok_in.cls = BC_MINUS;
			CH_SPACE, CH_TAB, CH_CR, CH_LF: tok_in.cls = BC_SPACE;
			default: begin
				if (in_byte inside {[CH_ZERO:CH_NINE]}) tok_in.cls = BC_DIGIT;
				else tok_in.cls = BC_OTHER;
			end
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= tok_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fjop_back.sv */
`default_nettype none
// ============================================================================
// fjop_back
// Parse state machine with number accumulator and registered result.
// ============================================================================
module fjop_back import fjop_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire tok_t q_tok,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	typedef enum logic [2:0] {
		ST_START,
		ST_WAIT_KEY,
		ST_KEY,
		ST_WAIT_COLON,
		ST_WAIT_VALUE,
		ST_STR,
		ST_NUM,
		ST_WAIT_END
	} state_t;

	state_t            state_q, state_n;
	logic [PAIR_W-1:0] pairs_q, pairs_n;
	logic [TLEN_W-1:0] tlen_q, tlen_n;
	logic [31:0]       mag_q, mag_n;
	logic              neg_q, neg_n;
	logic              out_valid_q;
	res_t              res_q, res_n;

	logic              ok, fin_num, fin_msg;
	logic [31:0]       mag_base;
	logic [35:0]       mag_acc;
	logic [31:0]       mag_dig;
	logic [31:0]       num_val;
	logic              is_space;

	assign q_pop     = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign is_space  = (q_tok.cls == BC_SPACE);

	// mag*10 + digit, saturated at 2^31
	always_comb begin
		mag_base = (state_q == ST_NUM) ? mag_q : 32'd0;
		mag_acc  = {1'b0, mag_base, 3'b000} + {3'b000, mag_base, 1'b0} + {32'd0, q_tok.digit};
		mag_dig  = (mag_acc >= {4'd0, MAG_CAP}) ? MAG_CAP : mag_acc[31:0];
		if (neg_q) num_val = 32'd0 - mag_q;
		else       num_val = mag_q[31] ? POS_SAT : mag_q;
	end

	always_comb begin
		state_n = state_q;
		pairs_n = pairs_q;
		tlen_n  = tlen_q;
		mag_n   = mag_q;
		neg_n   = neg_q;
		ok      = 1'b1;
		fin_num = 1'b0;
		fin_msg = 1'b0;
		res_n   = '0;

		case (state_q)
			ST_START: begin
				if (q_tok.cls == BC_LBRACE) state_n = ST_WAIT_KEY;
			end
			ST_WAIT_KEY: begin
				if (q_tok.cls == BC_QUOTE) begin
					if (pairs_q >= PAIR_LIMIT) ok = 1'b0;
					else begin
						state_n = ST_KEY;
						tlen_n  = '0;
					end
				end else if (!is_space) ok = 1'b0;
			end
			ST_KEY, ST_STR: begin
				if (q_tok.cls == BC_QUOTE) begin
					if (state_q == ST_KEY) state_n = ST_WAIT_COLON;
					else begin
						res_n.pair_done   = 1'b1;
						res_n.entry_index = pairs_q[IDX_W-1:0];
						pairs_n           = pairs_q + 1'b1;
						state_n           = ST_WAIT_END;
					end
				end else if (tlen_q >= TLEN_LIMIT) ok = 1'b0;
				else begin
					res_n.byte_role     = (state_q == ST_KEY) ? ROLE_KEY : ROLE_STR;
					res_n.char_out      = q_tok.raw;
					res_n.char_position = tlen_q;
					res_n.entry_index   = pairs_q[IDX_W-1:0];
					tlen_n              = tlen_q + 1'b1;
				end
			end
			ST_WAIT_COLON: begin
				if (q_tok.cls == BC_COLON) state_n = ST_WAIT_VALUE;
				else if (!is_space) ok = 1'b0;
			end
			ST_WAIT_VALUE: begin
				if (q_tok.cls == BC_QUOTE) begin
					state_n = ST_STR;
					tlen_n  = '0;
				end else if (q_tok.cls == BC_DIGIT || q_tok.cls == BC_MINUS) begin
					state_n             = ST_NUM;
					neg_n               = (q_tok.cls == BC_MINUS);
					mag_n               = (q_tok.cls == BC_MINUS) ? 32'd0 : mag_dig;
					res_n.byte_role     = ROLE_NUM;
					res_n.char_out      = q_tok.raw;
					res_n.entry_index   = pairs_q[IDX_W-1:0];
					tlen_n              = TLEN_W'(1);
				end else if (!is_space) ok = 1'b0;
			end
			ST_NUM: begin
				if (q_tok.cls == BC_COMMA) begin
					fin_num = 1'b1;
					state_n = ST_WAIT_KEY;
				end else if (q_tok.cls == BC_RBRACE) begin
					fin_num = 1'b1;
					fin_msg = 1'b1;
				end else if (is_space) begin
					fin_num = 1'b1;
					state_n = ST_WAIT_END;
				end else if (q_tok.cls == BC_DIGIT) begin
					if (tlen_q >= TLEN_LIMIT) ok = 1'b0;
					else begin
						mag_n               = mag_dig;
						res_n.byte_role     = ROLE_NUM;
						res_n.char_out      = q_tok.raw;
						res_n.char_position = tlen_q;
						res_n.entry_index   = pairs_q[IDX_W-1:0];
						tlen_n              = tlen_q + 1'b1;
					end
				end else ok = 1'b0;
			end
			ST_WAIT_END: begin
				if (q_tok.cls == BC_COMMA) state_n = ST_WAIT_KEY;
				else if (q_tok.cls == BC_RBRACE) fin_msg = 1'b1;
				else if (!is_space) ok = 1'b0;
			end
			default: ok = 1'b0;
		endcase

		if (fin_num) begin
			res_n.pair_done      = 1'b1;
			res_n.pair_is_number = 1'b1;
			res_n.entry_index    = pairs_q[IDX_W-1:0];
			res_n.number_value   = num_val;
			pairs_n              = pairs_q + 1'b1;
		end
		if (fin_msg) begin
			res_n.message_done = 1'b1;
			res_n.pair_total   = 4'(pairs_n);
		end
		if (fin_msg || !ok) begin
			state_n = ST_START;
			pairs_n = '0;
			tlen_n  = '0;
			mag_n   = '0;
			neg_n   = 1'b0;
		end
		if (!ok) res_n = '0;
		res_n.accepted = ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			pairs_q     <= '0;
			tlen_q      <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (q_pop) begin
				state_q <= state_n;
				pairs_q <= pairs_n;
				tlen_q  <= tlen_n;
				mag_q   <= mag_n;
				neg_q   <= neg_n;
				res_q   <= res_n;
			end
			if (q_pop) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/flat_json_object_byte_parser.sv */
`default_nettype none
// ============================================================================
// flat_json_object_byte_parser
// Streaming parser for a flat JSON object of string keys and string or
// integer values, one result per input byte.
// ============================================================================
// Usage:
//  - s_axis carries one text byte per transfer; every byte yields exactly one
//    result transfer on m_axis, in order.
//  - A byte is written into the 2-entry queue, then the back end steps the
//    parse state and loads the output register, which presents the result.
//  - Throughput: one byte per cycle sustained while m_axis takes results;
//    the parse state update plus the x10 accumulate of the number magnitude
//    is the feedback loop.
//  - When m_axis stalls, the output register holds its result, the back end
//    stops, and the queue absorbs up to two more bytes before s_axis_tready
//    drops. Nothing is lost or repeated.
//  - After arst_n the parser waits for an opening brace with all counters
//    cleared; the queue and output register are empty. No clearing pass.
//  - A rejected byte (syntax error, token or table overflow) reports
//    accepted = 0 with all other fields zero and resets the parser.
//  - m_axis_tlast marks the closing brace that completes an object.
// ============================================================================
module flat_json_object_byte_parser import fjop_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [0] accepted, [8:1] char_out, [13:9] char_position, [16:14] entry_index,
	// [17] pair_done, [18] pair_is_number, [50:19] number_value,
	// [54:51] pair_total, [55] zero
	output logic [55:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,   // [1:0] byte_role
	output logic             m_axis_tlast    // message_done
);

	logic q_valid;
	logic q_pop;
	tok_t q_tok;
	res_t res;

	// Front: byte transfer, classification, small decoupling queue
	fjop_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.q_valid  (q_valid),
		.q_tok    (q_tok),
		.q_pop    (q_pop)
	);

	// Back: parse state machine and output register
	fjop_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_tok     (q_tok),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// Pack result fields, lowest field in lowest bits
	assign m_axis_tdata = {1'b0,
	                       res.pair_total,
	                       res.number_value,
	                       res.pair_is_number,
	                       res.pair_done,
	                       res.entry_index,
	                       res.char_position,
	                       res.char_out,
	                       res.accepted};
	assign m_axis_tuser = res.byte_role;
	assign m_axis_tlast = res.message_done;

endmodule
`default_nettype wire

/* tb/sv/flat_json_object_byte_parser_tb.sv */
// ============================================================================
// flat_json_object_byte_parser_tb
// Self-checking bench for the flat JSON object byte parser. A clocked driver
// feeds text bytes from a queue and a clocked monitor checks every result
// against a cycle-free parser model kept in the bench. The text is mostly
// random well-formed objects, with some noise and some broken objects mixed
// in. Sender and receiver stall at random in the first two of three phases.
// ============================================================================
module flat_json_object_byte_parser_tb import fjop_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Parser states of the bench model
	typedef enum logic [2:0] {
		PS_IDLE,        // waiting for the opening brace
		PS_WAIT_KEY,
		PS_KEY,
		PS_WAIT_COLON,
		PS_WAIT_VALUE,
		PS_STR,
		PS_NUM,
		PS_WAIT_END     // after a value: comma or closing brace
	} parse_state_e;

	localparam int STALL_LIMIT = 1000;  // cycles with no transfer on either side

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] stream_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [0] accepted, [8:1] char_out, [13:9] char_position, [16:14] entry_index,
	// [17] pair_done, [18] pair_is_number, [50:19] number_value,
	// [54:51] pair_total, [55] zero
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;          // [1:0] byte_role
	logic        m_axis_tlast;          // message_done

	flat_json_object_byte_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	logic [7:0]  text_bytes[$];         // bytes waiting to be sent
	logic [7:0]  object_bytes[$];       // scratch for building one object
	res_t        predicted_results[$];  // one per sent byte, oldest first
	int unsigned bytes_queued = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	int unsigned send_idle_pct = 0;     // chance per cycle that the sender holds off
	int unsigned recv_idle_pct = 0;     // chance per cycle that tready is low

	// Numbers right at the int32 saturation edges
	string sat_edges[4] = '{"2147483647", "2147483648", "-2147483648", "-2147483649"};

	// Parser model state, at its reset values
	parse_state_e        json_state = PS_IDLE;
	logic [PAIR_W-1:0]   pairs_count = '0;
	logic [TLEN_W-1:0]   tok_len = '0;
	logic [31:0]         num_mag = '0;   // saturates at 2^31
	logic                num_neg = 1'b0;

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	function automatic void accumulate_digit(input logic [7:0] b);
		logic [63:0] wide;
		wide = 64'(num_mag) * 64'd10 + 64'(b - CH_ZERO);
		num_mag = (wide >= 64'(MAG_CAP)) ? MAG_CAP : wide[31:0];
	endfunction

	// Steps the model by one byte and returns the result it must produce.
	function automatic res_t parse_step(input logic [7:0] b);
		res_t r;
		logic ok, fin_num, fin_msg;
		r = '0;
		ok = 1'b1;
		fin_num = 1'b0;
		fin_msg = 1'b0;
		case (json_state)
			PS_IDLE: begin
				if (b == CH_LBRACE)
					json_state = PS_WAIT_KEY;
			end
			PS_WAIT_KEY: begin
				if (b == CH_QUOTE) begin
					// table full: one more key is an error
					if (pairs_count >= PAIR_LIMIT)
						ok = 1'b0;
					else begin
						json_state = PS_KEY;
						tok_len = '0;
					end
				end else if (!is_blank(b))
					ok = 1'b0;   // includes the empty object
			end
			PS_KEY, PS_STR: begin
				if (b == CH_QUOTE) begin
					if (json_state == PS_KEY)
						json_state = PS_WAIT_COLON;
					else begin
						r.pair_done = 1'b1;
						r.entry_index = pairs_count[IDX_W-1:0];
						pairs_count++;
						json_state = PS_WAIT_END;
					end
				end else if (tok_len >= TLEN_LIMIT)
					ok = 1'b0;   // token overflow
				else begin
					r.byte_role = (json_state == PS_KEY) ? ROLE_KEY : ROLE_STR;
					r.char_out = b;
					r.char_position = tok_len;
					r.entry_index = pairs_count[IDX_W-1:0];
					tok_len++;
				end
			end
			PS_WAIT_COLON: begin
				if (b == CH_COLON)
					json_state = PS_WAIT_VALUE;
				else if (!is_blank(b))
					ok = 1'b0;
			end
			PS_WAIT_VALUE: begin
				if (b == CH_QUOTE) begin
					json_state = PS_STR;
					tok_len = '0;
				end else if (is_digit(b) || b == CH_MINUS) begin
					json_state = PS_NUM;
					num_mag = '0;
					num_neg = (b == CH_MINUS);
					if (b != CH_MINUS)
						accumulate_digit(b);
					r.byte_role = ROLE_NUM;
					r.char_out = b;
					r.entry_index = pairs_count[IDX_W-1:0];
					tok_len = TLEN_W'(1);
				end else if (!is_blank(b))
					ok = 1'b0;
			end
			PS_NUM: begin
				if (b == CH_COMMA) begin
					fin_num = 1'b1;
					json_state = PS_WAIT_KEY;
				end else if (b == CH_RBRACE) begin
					fin_num = 1'b1;
					fin_msg = 1'b1;
				end else if (is_blank(b)) begin
					fin_num = 1'b1;
					json_state = PS_WAIT_END;
				end else if (is_digit(b)) begin
					if (tok_len >= TLEN_LIMIT)
						ok = 1'b0;
					else begin
						accumulate_digit(b);
						r.byte_role = ROLE_NUM;
						r.char_out = b;
						r.char_position = tok_len;
						r.entry_index = pairs_count[IDX_W-1:0];
						tok_len++;
					end
				end else
					ok = 1'b0;
			end
			default: begin
				if (b == CH_COMMA)
					json_state = PS_WAIT_KEY;
				else if (b == CH_RBRACE)
					fin_msg = 1'b1;
				else if (!is_blank(b))
					ok = 1'b0;
			end
		endcase

		if (ok && fin_num) begin
			r.pair_done = 1'b1;
			r.pair_is_number = 1'b1;
			r.entry_index = pairs_count[IDX_W-1:0];
			// lone minus gives 0; saturated magnitude gives the int32 extremes
			if (num_neg)
				r.number_value = 32'd0 - num_mag;
			else
				r.number_value = (num_mag >= MAG_CAP) ? POS_SAT : num_mag;
			pairs_count++;
		end
		if (ok && fin_msg) begin
			r.message_done = 1'b1;
			r.pair_total = 4'(pairs_count);
		end
		if (!ok)
			r = '0;
		r.accepted = ok;
		if (!ok || fin_msg) begin
			json_state = PS_IDLE;
			pairs_count = '0;
			tok_len = '0;
			num_mag = '0;
			num_neg = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	task automatic report_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		mismatches++;
		$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
			$time, fname, exp_v, got_v);
	endtask

	task automatic check_result(input res_t exp_r, input res_t got_r);
		if (got_r.accepted !== exp_r.accepted)
			report_field("accepted", 32'(exp_r.accepted), 32'(got_r.accepted));
		if (got_r.byte_role !== exp_r.byte_role)
			report_field("byte_role", 32'(exp_r.byte_role), 32'(got_r.byte_role));
		if (got_r.char_out !== exp_r.char_out)
			report_field("char_out", 32'(exp_r.char_out), 32'(got_r.char_out));
		if (got_r.char_position !== exp_r.char_position)
			report_field("char_position", 32'(exp_r.char_position),
				32'(got_r.char_position));
		if (got_r.entry_index !== exp_r.entry_index)
			report_field("entry_index", 32'(exp_r.entry_index), 32'(got_r.entry_index));
		if (got_r.pair_done !== exp_r.pair_done)
			report_field("pair_done", 32'(exp_r.pair_done), 32'(got_r.pair_done));
		if (got_r.pair_is_number !== exp_r.pair_is_number)
			report_field("pair_is_number", 32'(exp_r.pair_is_number),
				32'(got_r.pair_is_number));
		if (got_r.number_value !== exp_r.number_value)
			report_field("number_value", exp_r.number_value, got_r.number_value);
		if (got_r.message_done !== exp_r.message_done)
			report_field("message_done", 32'(exp_r.message_done), 32'(got_r.message_done));
		if (got_r.pair_total !== exp_r.pair_total)
			report_field("pair_total", 32'(exp_r.pair_total), 32'(got_r.pair_total));
	endtask

	// ------------------------------------------------------------------------
	// Driver: holds tvalid/tdata until the transfer, predicts on each transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'd0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predicted_results.push_back(parse_step(s_axis_tdata));
				void'(text_bytes.pop_front());
			end
			// free to move on when nothing is offered or the offer just went
			if (!s_axis_tvalid || s_axis_tready) begin
				if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= text_bytes[0];
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: unpacks each result transfer and checks it, drives tready
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		res_t got;
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.accepted = m_axis_tdata[0];
				got.char_out = m_axis_tdata[8:1];
				got.char_position = m_axis_tdata[13:9];
				got.entry_index = m_axis_tdata[16:14];
				got.pair_done = m_axis_tdata[17];
				got.pair_is_number = m_axis_tdata[18];
				got.number_value = m_axis_tdata[50:19];
				got.pair_total = m_axis_tdata[54:51];
				got.byte_role = m_axis_tuser;
				got.message_done = m_axis_tlast;
				if (predicted_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: result transfer with none expected, actual 0x%0h",
						$time, m_axis_tdata);
				end else
					check_result(predicted_results.pop_front(), got);
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("flat_json_object_byte_parser regression: fail");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic enqueue(input logic [7:0] b);
		text_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic enqueue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			enqueue(s[i]);
	endtask

	task automatic add_blanks();
		int n;
		n = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) begin
			case ($urandom_range(3))
				0: object_bytes.push_back(CH_SPACE);
				1: object_bytes.push_back(CH_TAB);
				2: object_bytes.push_back(CH_CR);
				default: object_bytes.push_back(CH_LF);
			endcase
		end
	endtask

	// Any byte but a quote; long enough now and then to hit the token limit
	task automatic add_quoted_token();
		logic [7:0] b;
		int n;
		n = ($urandom_range(24) == 0) ? $urandom_range(TOKEN_BYTES - 3, TOKEN_BYTES)
			: $urandom_range(0, 6);
		object_bytes.push_back(CH_QUOTE);
		repeat (n) begin
			do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
			object_bytes.push_back(b);
		end
		object_bytes.push_back(CH_QUOTE);
	endtask

	task automatic add_number();
		string s;
		logic neg;
		int digits;
		if ($urandom_range(9) == 0) begin
			s = sat_edges[$urandom_range(3)];
			for (int i = 0; i < s.len(); i++)
				object_bytes.push_back(s[i]);
		end else begin
			neg = ($urandom_range(3) == 0);
			case ($urandom_range(19))
				0, 1: digits = $urandom_range(TOKEN_BYTES - 3, TOKEN_BYTES);
				2: digits = 0;   // lone minus when negative
				default: digits = $urandom_range(1, 12);
			endcase
			if (!neg && digits == 0)
				digits = 1;
			if (neg)
				object_bytes.push_back(CH_MINUS);
			repeat (digits)
				object_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	// One object with random content; sometimes noise ahead, a bad byte or a cut
	task automatic queue_object();
		int npairs, cut;
		object_bytes.delete();
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 4))
				object_bytes.push_back(8'($urandom_range(255)));
		object_bytes.push_back(CH_LBRACE);
		npairs = ($urandom_range(14) == 0) ? MAX_PAIRS + 1 : $urandom_range(1, MAX_PAIRS);
		for (int p = 0; p < npairs; p++) begin
			add_blanks();
			add_quoted_token();
			add_blanks();
			object_bytes.push_back(CH_COLON);
			add_blanks();
			if ($urandom_range(1))
				add_quoted_token();
			else
				add_number();
			add_blanks();
			object_bytes.push_back((p == npairs - 1) ? CH_RBRACE : CH_COMMA);
		end
		cut = object_bytes.size();
		case ($urandom_range(13))
			0: object_bytes[$urandom_range(cut - 1)] = 8'($urandom_range(255));
			1: cut = $urandom_range(1, cut - 1);
			default: ;
		endcase
		for (int i = 0; i < cut; i++)
			enqueue(object_bytes[i]);
	endtask

	task automatic queue_phase(input int unsigned upto);
		while (bytes_queued < upto) begin
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, 8))
					enqueue(8'($urandom_range(255)));
			else
				queue_object();
		end
	endtask

	// Waits until every queued byte is sent and every predicted result has come back
	task automatic drain();
		while (text_bytes.size() != 0 || predicted_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// phase 1: sender idles often, receiver stalls half the time
		send_idle_pct = 29;
		recv_idle_pct = 50;
		// directed: stray top-bit byte, empty object, lone minus, low saturation
		enqueue(8'hFF);
		enqueue_text("{}");
		enqueue_text("{\"\":-}");
		enqueue_text("{\"\":-2147483649}");
		queue_phase(220);
		drain();

		// phase 2: roles swapped
		send_idle_pct = 50;
		recv_idle_pct = 29;
		queue_phase(420);
		drain();

		// phase 3: back to back, no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_phase(620);
		drain();

		repeat (5) @(negedge clk);
		if (mismatches == 0)
			$display("flat_json_object_byte_parser regression: pass");
		else
			$display("flat_json_object_byte_parser regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/fjop_pkg.sv
hw/rtl/fjop_front.sv
hw/rtl/fjop_back.sv
hw/rtl/flat_json_object_byte_parser.sv
tb/sv/flat_json_object_byte_parser_tb.sv
